// ===== hw/rtl/char_grid_rotator_assert.svh =====
// ----------------------------------------------------------------------------
// char grid rotator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_GRID_ROTATOR_ASSERT_SVH
`define CHAR_GRID_ROTATOR_ASSERT_SVH

// same-cycle implication
`define CGR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cgr_pkg.sv =====
// ----------------------------------------------------------------------------
// cgr_pkg
// Shared types and constants of the character grid rotator.
// ----------------------------------------------------------------------------
package cgr_pkg;

    localparam int DEF_MAX_SIDE = 8;
    localparam int CHAR_W       = 8;
    localparam int COORD_W      = 3;
    localparam int CFG_SIDE_W   = 4;
    localparam int CFG_ROT_W    = 9;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [CHAR_W-1:0]     PAD_CHAR = 8'h20;
    localparam logic [CFG_ROT_W-1:0]  ROT_90   = 9'd90;
    localparam logic [CFG_ROT_W-1:0]  ROT_180  = 9'd180;
    localparam logic [CFG_ROT_W-1:0]  ROT_270  = 9'd270;

    localparam logic [CFG_SIDE_W-1:0] RST_HEIGHT = 4'd8;
    localparam logic [CFG_SIDE_W-1:0] RST_WIDTH  = 4'd8;
    localparam logic [CFG_ROT_W-1:0]  RST_ROT    = 9'd0;

    typedef enum logic [1:0] {
        REG_HEIGHT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_ROT    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_SIDE_W-1:0] height;
        logic [CFG_SIDE_W-1:0] width;
        logic [CFG_ROT_W-1:0]  rot;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic accept;
        logic issue;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic grid_done;
        logic last_pos;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/char_grid_rotator.sv =====
// ----------------------------------------------------------------------------
// char_grid_rotator
// Loads a character grid line by line and streams it out rotated by a
// multiple of 90 degrees, one cell per result with its coordinates.
//
//   channel   direction  payload
//   s_axis    in         tdata: in_char; tuser: char_valid; tlast: line_end
//   m_axis    out        tdata: out_char, out_row, out_col; tlast: last
//   apb       in/out     grid_height @0x0, grid_width @0x4, rotation_degrees @0x8
//
// Input items can be taken back to back; a line end needs no padding items since
// each row's length is kept and short rows read back as spaces.
// Readout takes each result through an address issue step, then a registered
// read of the grid RAM into the output register, and waits on any m_axis stall.
// s_axis is held off while a grid is read out, from the line end that
// completes it until the last result is loaded.
// Reset is synchronous; the grid RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module char_grid_rotator
    import cgr_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] in_char
    input  logic                   s_axis_tuser,  // [0] char_valid
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_char, [10:8] out_row,
                                                  // [13:11] out_col, [15:14] zero
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg               cfg;
    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [CHAR_W-1:0]  out_char;
    logic [COORD_W-1:0] out_row, out_col;

    cgr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cgr_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_in_char       (s_axis_tdata[CHAR_W-1:0]),
        .i_in_char_valid (s_axis_tuser),
        .i_in_line_end   (s_axis_tlast),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_char      (out_char),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_col, out_row, out_char};

endmodule

// ===== hw/rtl/cgr_ram.sv =====
// ----------------------------------------------------------------------------
// cgr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cgr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cgr_regs.sv =====
// ----------------------------------------------------------------------------
// cgr_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module cgr_regs
    import cgr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height <= RST_HEIGHT;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.rot    <= RST_ROT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEIGHT: r_cfg.height <= pwdata[CFG_SIDE_W-1:0];
                REG_WIDTH:  r_cfg.width  <= pwdata[CFG_SIDE_W-1:0];
                REG_ROT:    r_cfg.rot    <= pwdata[CFG_ROT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEIGHT: prdata = APB_DATA_W'(r_cfg.height);
            REG_WIDTH:  prdata = APB_DATA_W'(r_cfg.width);
            REG_ROT:    prdata = APB_DATA_W'(r_cfg.rot);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/cgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgr_ctrl
// Sequencer: takes characters, then walks the rotated readout one cell at a time.
// ----------------------------------------------------------------------------
module cgr_ctrl
    import cgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_LOAD
    } t_state;

    t_state  r_state, n_state;
    logic    r_in_ready, n_in_ready;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.accept = i_in_valid & r_in_ready;
                if (cmd.accept && i_status.grid_done) begin
                    cmd.start = 1'b1;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                // wait until the output register can take the next cell
                if (i_status.out_free) begin
                    cmd.issue = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                n_state  = i_status.last_pos ? S_IDLE : S_ISSUE;
            end
            default: n_state = S_IDLE;
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

// ===== hw/rtl/cgr_dp.sv =====
// ----------------------------------------------------------------------------
// cgr_dp
// Datapath: grid store, line bookkeeping, rotated address generation and
// the output register.
// ----------------------------------------------------------------------------
module cgr_dp
    import cgr_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [CHAR_W-1:0]  i_in_char,
    input  logic               i_in_char_valid,
    input  logic               i_in_line_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CHAR_W-1:0]  o_out_char,
    output logic [COORD_W-1:0] o_out_row,
    output logic [COORD_W-1:0] o_out_col,
    output logic               o_out_last
);

    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CNT_W  = $clog2(MAX_SIDE + 1);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [CNT_W-1:0] side_of(input logic [CFG_SIDE_W-1:0] v);
        logic [CNT_W-1:0] s;
        if (v == '0) begin
            s = CNT_W'(1);
        end else if (v > MAX_SIDE) begin
            s = CNT_W'(MAX_SIDE);
        end else begin
            s = CNT_W'(v);
        end
        return s;
    endfunction

    // config-derived geometry
    logic [CNT_W-1:0] h, w, oh, ow;
    logic [IDX_W-1:0] hm1, wm1;
    logic             is90, is180, is270;

    // load side
    logic [CNT_W-1:0]  r_line, r_col;
    logic [CNT_W-1:0]  r_row_len [MAX_SIDE];
    logic [CNT_W-1:0]  line_inc, col_after;
    logic [IDX_W-1:0]  load_row;
    logic              store, grid_done;
    logic [ADDR_W-1:0] waddr;

    // readout side
    logic [IDX_W-1:0]  r_orow, r_ocol;
    logic [IDX_W-1:0]  src_row, src_col, r_src_row, r_src_col;
    logic [ADDR_W-1:0] raddr;
    logic [CHAR_W-1:0] ram_rdata;
    logic              last_pos, cell_stored;

    // output register
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [COORD_W-1:0] r_out_row, r_out_col;
    logic               r_out_last;

    assign h     = side_of(i_cfg.height);
    assign w     = side_of(i_cfg.width);
    assign hm1   = IDX_W'(h - 1'b1);
    assign wm1   = IDX_W'(w - 1'b1);
    assign is90  = (i_cfg.rot == ROT_90);
    assign is180 = (i_cfg.rot == ROT_180);
    assign is270 = (i_cfg.rot == ROT_270);
    assign oh    = (is90 | is270) ? w : h;
    assign ow    = (is90 | is270) ? h : w;

    // ---------------- load side ----------------
    assign load_row  = r_line[IDX_W-1:0];
    assign line_inc  = r_line + 1'b1;
    assign grid_done = i_in_line_end && (line_inc >= h);
    assign store     = i_cmd.accept && i_in_char_valid && (r_col < w);
    assign col_after = store ? (r_col + 1'b1) : r_col;
    assign waddr     = ADDR_W'(load_row * MAX_SIDE + r_col[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_col  <= '0;
        end else if (i_cmd.accept) begin
            if (i_in_line_end) begin
                r_col  <= '0;
                r_line <= grid_done ? '0 : line_inc;
            end else begin
                r_col  <= col_after;
            end
        end
    end

    // cells at or past a row's length read back as padding
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_line_end) begin
            r_row_len[load_row] <= col_after;
        end
    end

    // ---------------- readout side ----------------
    always_comb begin
        priority if (is90) begin
            src_row = hm1 - r_ocol;
            src_col = r_orow;
        end else if (is180) begin
            src_row = hm1 - r_orow;
            src_col = wm1 - r_ocol;
        end else if (is270) begin
            src_row = r_ocol;
            src_col = wm1 - r_orow;
        end else begin
            src_row = r_orow;
            src_col = r_ocol;
        end
    end

    assign raddr    = ADDR_W'(src_row * MAX_SIDE + src_col);
    assign last_pos = (r_orow == IDX_W'(oh - 1'b1)) && (r_ocol == IDX_W'(ow - 1'b1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_src_row <= src_row;
            r_src_col <= src_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orow <= '0;
            r_ocol <= '0;
        end else if (i_cmd.start) begin
            r_orow <= '0;
            r_ocol <= '0;
        end else if (i_cmd.load && !last_pos) begin
            if (r_ocol == IDX_W'(ow - 1'b1)) begin
                r_ocol <= '0;
                r_orow <= r_orow + 1'b1;
            end else begin
                r_ocol <= r_ocol + 1'b1;
            end
        end
    end

    cgr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (waddr),
        .i_wdata (i_in_char),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign cell_stored = (CNT_W'(r_src_col) < r_row_len[r_src_row]);

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_char <= cell_stored ? ram_rdata : PAD_CHAR;
            r_out_row  <= COORD_W'(r_orow);
            r_out_col  <= COORD_W'(r_ocol);
            r_out_last <= last_pos;
        end
    end

    assign o_status.grid_done = grid_done;
    assign o_status.last_pos  = last_pos;
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_last  = r_out_last;

endmodule

// ===== hw/rtl/char_grid_rotator_chk.sv =====
// ----------------------------------------------------------------------------
// char_grid_rotator_chk
// Port-level checks on the rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_grid_rotator_assert.svh"

module char_grid_rotator_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result holds
    `CGR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // a request that does not end a line never starts a readout
    `CGR_ASSERT_NEXT(a_no_early_out, s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid, !m_axis_tvalid, "result without a line end")

    // no character taken in the middle of a readout
    `CGR_ASSERT_IMPL(a_busy_readout, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during readout")

endmodule

bind char_grid_rotator char_grid_rotator_chk u_chk (.*);

// ===== sim/grid_rotation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_rotation_checker
// Watches the character stream, the rotated-cell stream and the register
// port of the grid rotator. Keeps its own copy of the grid and the settings,
// works out every rotated cell a line end should release, and compares each
// cell taken from m_axis with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module grid_rotation_checker
    import cgr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_char
    input  logic                   s_axis_tuser,   // [0] char_valid
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_char, [10:8] out_row,
                                                   // [13:11] out_col, [15:14] zero
    input  logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output int                     o_error_count,
    output int                     o_pending,
    output int                     o_cells_checked,
    output int                     o_grids_done
);

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               is_last;
    } t_rotated_cell;

    t_rotated_cell         rotated_cells_q[$];
    logic [CHAR_W-1:0]     grid_chars [DEF_MAX_SIDE*DEF_MAX_SIDE];
    logic [CFG_SIDE_W-1:0] height_reg;
    logic [CFG_SIDE_W-1:0] width_reg;
    logic [CFG_ROT_W-1:0]  rot_reg;
    logic [3:0]            line_idx;
    logic [3:0]            col_idx;
    int                    error_count;
    int                    cells_checked;
    int                    grids_done;

    function automatic int side_len(input logic [CFG_SIDE_W-1:0] v);
        if (v == '0) return 1;
        if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
        return int'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40) $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic emit_rotated_grid;
        int            h;
        int            w;
        int            out_h;
        int            out_w;
        int            total;
        int            k;
        int            r;
        int            c;
        int            src_r;
        int            src_c;
        logic          turned;
        t_rotated_cell exp_cell;
        h      = side_len(height_reg);
        w      = side_len(width_reg);
        turned = (rot_reg == ROT_90) || (rot_reg == ROT_270);
        out_h  = turned ? w : h;
        out_w  = turned ? h : w;
        total  = out_h * out_w;
        k      = 0;
        for (r = 0; r < out_h; r++) begin
            for (c = 0; c < out_w; c++) begin
                if (rot_reg == ROT_90) begin
                    src_r = h - 1 - c;
                    src_c = r;
                end else if (rot_reg == ROT_180) begin
                    src_r = h - 1 - r;
                    src_c = w - 1 - c;
                end else if (rot_reg == ROT_270) begin
                    src_r = c;
                    src_c = w - 1 - r;
                end else begin
                    // any other angle is a straight copy
                    src_r = r;
                    src_c = c;
                end
                exp_cell.ch      = grid_chars[src_r*DEF_MAX_SIDE + src_c];
                exp_cell.row     = COORD_W'(r);
                exp_cell.col     = COORD_W'(c);
                exp_cell.is_last = (k + 1 == total);
                rotated_cells_q.push_back(exp_cell);
                k++;
            end
        end
        grids_done++;
    endtask

    task automatic load_grid_char(input logic [CHAR_W-1:0] ch, input logic valid,
                                  input logic eol);
        int row;
        int c;
        row = int'(line_idx[2:0]);
        if (valid && col_idx < side_len(width_reg)) begin
            grid_chars[row*DEF_MAX_SIDE + int'(col_idx)] = ch;
            col_idx++;
        end
        if (eol) begin
            // rest of the row always reads back as spaces
            for (c = int'(col_idx); c < DEF_MAX_SIDE; c++)
                grid_chars[row*DEF_MAX_SIDE + c] = PAD_CHAR;
            col_idx  = '0;
            line_idx = line_idx + 4'd1;
            if (line_idx >= side_len(height_reg)) begin
                line_idx = '0;
                emit_rotated_grid();
            end
        end
    endtask

    task automatic check_rotated_cell;
        t_rotated_cell      want;
        logic [CHAR_W-1:0]  got_ch;
        logic [COORD_W-1:0] got_row;
        logic [COORD_W-1:0] got_col;
        got_ch  = m_axis_tdata[CHAR_W-1:0];
        got_row = m_axis_tdata[CHAR_W +: COORD_W];
        got_col = m_axis_tdata[CHAR_W+COORD_W +: COORD_W];
        if (rotated_cells_q.size() == 0) begin
            report_mismatch($sformatf("cell %h/%b arrived with nothing outstanding",
                                      m_axis_tdata, m_axis_tlast));
            return;
        end
        want = rotated_cells_q.pop_front();
        cells_checked++;
        if (got_ch != want.ch)
            report_mismatch($sformatf("out_char %h, want %h (row %0d col %0d)",
                                      got_ch, want.ch, want.row, want.col));
        if (got_row != want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", got_row, want.row));
        if (got_col != want.col)
            report_mismatch($sformatf("out_col %0d, want %0d", got_col, want.col));
        if (m_axis_tdata[OUT_TDATA_W-1:CHAR_W+2*COORD_W] != '0)
            report_mismatch($sformatf("tdata fill bits set: %h", m_axis_tdata));
        if (m_axis_tlast != want.is_last)
            report_mismatch($sformatf("tlast %b, want %b (row %0d col %0d)",
                                      m_axis_tlast, want.is_last, want.row, want.col));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rotated_cells_q.delete();
            height_reg    = RST_HEIGHT;
            width_reg     = RST_WIDTH;
            rot_reg       = RST_ROT;
            line_idx      = '0;
            col_idx       = '0;
            error_count   = 0;
            cells_checked = 0;
            grids_done    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_HEIGHT: height_reg = pwdata[CFG_SIDE_W-1:0];
                    REG_WIDTH:  width_reg  = pwdata[CFG_SIDE_W-1:0];
                    REG_ROT:    rot_reg    = pwdata[CFG_ROT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                load_grid_char(s_axis_tdata[CHAR_W-1:0], s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_rotated_cell();
        end
        o_error_count   <= error_count;
        o_pending       <= rotated_cells_q.size();
        o_cells_checked <= cells_checked;
        o_grids_done    <= grids_done;
    end

endmodule

// ===== sim/tb_char_grid_rotator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_grid_rotator
// Drives character lines and register settings into the grid rotator with
// bursty input and a stalling output, including one long output hold-off,
// and leaves all prediction and comparison to grid_rotation_checker.
// ----------------------------------------------------------------------------
module tb_char_grid_rotator;
    import cgr_pkg::*;

    localparam int TOTAL_ITEMS = 380;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_GAP    = 8;
    localparam int LONG_HOLD   = 400;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] in_char
    logic                   s_axis_tuser  = 1'b0; // [0] char_valid
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] out_char, [10:8] out_row,
                                                  // [13:11] out_col, [15:14] zero
    logic                   m_axis_tlast;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int         error_count;
    int         pending;
    int         cells_checked;
    int         grids_done;
    int         items_sent    = 0;
    int         settings_used = 0;
    int         burst_left    = 0;
    int         tx_gap_max    = 4;
    int         stall_cycles  = 0;
    int         rx_hold_left  = 0;
    logic       rx_hold_go    = 1'b0;
    logic       rx_hold_done  = 1'b0;
    logic [9:0] rx_tick       = '0;

    always #4 i_clk = ~i_clk;

    char_grid_rotator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    grid_rotation_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_error_count   (error_count),
        .o_pending       (pending),
        .o_cells_checked (cells_checked),
        .o_grids_done    (grids_done)
    );

    // output side: stall pattern changes with the upper bits of rx_tick, one long hold-off on demand
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 10'd1;
        if (rx_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (rx_hold_go && !rx_hold_done) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= LONG_HOLD;
            rx_hold_done  <= 1'b1;
        end else begin
            case (rx_tick[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles, %0d cells outstanding",
                     stall_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic valid,
                             input logic eol);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= valid;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
        if (valid || eol) items_sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(input logic [CFG_SIDE_W-1:0] hgt,
                             input logic [CFG_SIDE_W-1:0] wid,
                             input logic [CFG_ROT_W-1:0] rot);
        write_reg(REG_HEIGHT, APB_DATA_W'(hgt));
        write_reg(REG_WIDTH, APB_DATA_W'(wid));
        write_reg(REG_ROT, APB_DATA_W'(rot));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // stop offering, let every outstanding cell drain, then give the block time to settle
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    // well-formed lines of random length, with some ignored requests mixed in
    task automatic send_lines(input int n_lines, input int wid);
        int n;
        int len;
        int k;
        for (n = 0; n < n_lines; n++) begin
            len = $urandom_range(0, wid + 2);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            send_item(CHAR_W'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0), 1'b1);
        end
    endtask

    function automatic int eff_side(input logic [CFG_SIDE_W-1:0] v);
        if (v == '0) return 1;
        if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
        return int'(v);
    endfunction

    function automatic logic [CFG_SIDE_W-1:0] pick_side;
        if ($urandom_range(0, 9) < 7) return CFG_SIDE_W'($urandom_range(1, 4));
        return CFG_SIDE_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [CFG_ROT_W-1:0] pick_rot;
        case ($urandom_range(0, 4))
            0: return RST_ROT;
            1: return ROT_90;
            2: return ROT_180;
            3: return ROT_270;
            default: return CFG_ROT_W'($urandom_range(0, 511));
        endcase
    endfunction

    initial begin
        int                    phase;
        int                    i;
        int                    h_eff;
        int                    w_eff;
        logic [CFG_SIDE_W-1:0] hgt;
        logic [CFG_SIDE_W-1:0] wid;
        logic [CFG_ROT_W-1:0]  rot;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 turned by 90: overlong line, carried char past width, empty line
        configure(4'd2, 4'd3, ROT_90);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'h42, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h7E, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();

        // zero width reads as one, char carried on the line end
        configure(4'd1, 4'd0, ROT_180);
        send_item(8'h55, 1'b1, 1'b1);
        wait_drained();

        // zero height and saturated width, one char too many
        configure(4'd0, 4'd15, ROT_270);
        for (i = 0; i < 9; i++) send_item(CHAR_W'(8'h30 + i), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();

        // height lowered while a grid is half loaded
        configure(4'd15, 4'd1, 9'd511);
        send_item(8'h31, 1'b1, 1'b1);
        send_item(8'h32, 1'b1, 1'b1);
        wait_drained();
        configure(4'd3, 4'd1, 9'd360);
        send_item(8'h33, 1'b1, 1'b1);
        wait_drained();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            hgt = pick_side();
            wid = pick_side();
            rot = pick_rot();
            if (phase == 1) begin
                // full-size grids while the output holds off, so the input backs up
                hgt = 4'd8;
                wid = 4'd8;
                rx_hold_go <= 1'b1;
            end
            tx_gap_max = (phase % 3 == 0) ? 0 : 6;
            configure(hgt, wid, rot);
            h_eff = eff_side(hgt);
            w_eff = eff_side(wid);
            send_lines((phase == 1 ? 2 : $urandom_range(1, 3)) * h_eff, w_eff);
            // sometimes leave a grid unfinished for the next setting to pick up
            if (h_eff > 1 && $urandom_range(0, 5) == 0)
                send_lines($urandom_range(1, h_eff - 1), w_eff);
            wait_drained();
            phase++;
        end

        repeat (IDLE_GAP) @(posedge i_clk);
        $display("run: %0d line requests under %0d register settings, one %0d-cycle output hold",
                 items_sent, settings_used, LONG_HOLD);
        $display("run: %0d grids read out, %0d rotated cells compared, %0d mismatches",
                 grids_done, cells_checked, error_count);
        if (error_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cgr_pkg.sv
hw/rtl/cgr_ram.sv
hw/rtl/cgr_regs.sv
hw/rtl/cgr_ctrl.sv
hw/rtl/cgr_dp.sv
hw/rtl/char_grid_rotator.sv
hw/rtl/char_grid_rotator_chk.sv
sim/grid_rotation_checker.sv
sim/tb_char_grid_rotator.sv
